FILE: rtl/i2c_master_register_access_assert.svh
// ----------------------------------------------------------------------------
// i2c master register access - assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// clocked property, switched off while reset is held
`define I2CM_ASSERT_RST(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("i2cm assertion failed");

// clocked property that also holds across reset
`define I2CM_ASSERT_ALL(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("i2cm assertion failed");

`endif

FILE: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// types, step table and phase entry logic of the i2c register sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam int PHASE_CNT_W_DEF = 16;
  localparam int DEV_ADDR_W      = 7;
  localparam int TICKS_W         = 16;
  localparam int STEP_W          = 6;
  localparam int BYTE_W          = 8;
  localparam int BITCNT_W        = 4;

  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RST    = 7'd50;
  localparam logic [TICKS_W-1:0]    PHASE_TICKS_RST = 16'd10;

  localparam logic [STEP_W-1:0]   STEP_IDLE   = 6'd0;
  localparam logic [STEP_W-1:0]   WRITE_FIRST = 6'd1;
  localparam logic [STEP_W-1:0]   READ_FIRST  = 6'd18;
  localparam logic [BITCNT_W-1:0] BIT_LAST    = 4'd7;

  // register indexes of the config port
  localparam logic CFG_DEV_ADDR    = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  typedef enum logic [3:0] {
    K_IDLE, K_STA, K_STB, K_TXLO, K_TXHI, K_ACKLO, K_ACKHI,
    K_RXLO, K_RXHI, K_NKLO, K_NKHI, K_SPA, K_SPB, K_SPC
  } kind_t;

  typedef enum logic [2:0] {
    L_NONE, L_AW, L_REG, L_VAL, L_AR
  } load_t;

  typedef struct packed {
    kind_t kind;
    load_t load;
  } step_ent_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } lines_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [BYTE_W-1:0] tx;
    lines_t            lines;
  } enter_t;

  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              drv;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rd_data;
  } result_t;

  localparam lines_t LINES_RST = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};

  // write transfer occupies steps 1..17, read transfer 18..40
  function automatic step_ent_t step_entry(input logic [STEP_W-1:0] step);
    step_ent_t e;
    e.kind = K_IDLE;
    e.load = L_NONE;
    case (step) inside
      6'd1, 6'd18, 6'd28:                      e.kind = K_STA;
      6'd2, 6'd19, 6'd29:                      e.kind = K_STB;
      6'd3, 6'd20: begin
        e.kind = K_TXLO;
        e.load = L_AW;
      end
      6'd7, 6'd24: begin
        e.kind = K_TXLO;
        e.load = L_REG;
      end
      6'd11: begin
        e.kind = K_TXLO;
        e.load = L_VAL;
      end
      6'd30: begin
        e.kind = K_TXLO;
        e.load = L_AR;
      end
      6'd4, 6'd8, 6'd12, 6'd21, 6'd25, 6'd31:  e.kind = K_TXHI;
      6'd5, 6'd9, 6'd13, 6'd22, 6'd26, 6'd32:  e.kind = K_ACKLO;
      6'd6, 6'd10, 6'd14, 6'd23, 6'd27, 6'd33: e.kind = K_ACKHI;
      6'd34:                                   e.kind = K_RXLO;
      6'd35:                                   e.kind = K_RXHI;
      6'd36:                                   e.kind = K_NKLO;
      6'd37:                                   e.kind = K_NKHI;
      6'd15, 6'd38:                            e.kind = K_SPA;
      6'd16, 6'd39:                            e.kind = K_SPB;
      6'd17, 6'd40:                            e.kind = K_SPC;
      default:                                 e.kind = K_IDLE;
    endcase
    return e;
  endfunction

  // new step: reload the shifter on the first bit of a byte, set the lines
  function automatic enter_t enter_step(
    input logic [STEP_W-1:0]     step,
    input logic [BITCNT_W-1:0]   bit_cnt,
    input logic [BYTE_W-1:0]     tx,
    input logic [DEV_ADDR_W-1:0] dev_addr,
    input logic [BYTE_W-1:0]     reg_idx,
    input logic [BYTE_W-1:0]     value
  );
    enter_t    r;
    step_ent_t e;
    logic      msb;
    e      = step_entry(step);
    r.step = step;
    r.tx   = tx;
    if (e.kind == K_TXLO && bit_cnt == '0) begin
      case (e.load)
        L_AW:    r.tx = {dev_addr, 1'b0};
        L_AR:    r.tx = {dev_addr, 1'b1};
        L_REG:   r.tx = reg_idx;
        default: r.tx = value;
      endcase
    end
    msb = r.tx[BYTE_W-1];
    case (e.kind)
      K_STA:   r.lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      K_STB:   r.lines = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
      K_TXLO:  r.lines = '{scl: 1'b0, sda: msb,  drv: 1'b1};
      K_TXHI:  r.lines = '{scl: 1'b1, sda: msb,  drv: 1'b1};
      K_ACKLO: r.lines = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
      K_ACKHI: r.lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
      K_RXLO:  r.lines = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
      K_RXHI:  r.lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
      K_NKLO:  r.lines = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
      K_NKHI:  r.lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      K_SPA:   r.lines = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
      K_SPB:   r.lines = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
      default: r.lines = LINES_RST;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/i2cm_seq.sv
// ----------------------------------------------------------------------------
// i2cm_seq
// bus sequencer state and one-tick next-state logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_seq #(
  parameter int PHASE_COUNTER_WIDTH = i2cm_pkg::PHASE_CNT_W_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               adv,
  input  wire logic                               req_valid,
  input  wire logic                               op,
  input  wire logic [i2cm_pkg::BYTE_W-1:0]        reg_idx,
  input  wire logic [i2cm_pkg::BYTE_W-1:0]        wr_value,
  input  wire logic                               sda_in,
  input  wire logic [i2cm_pkg::DEV_ADDR_W-1:0]    dev_addr,
  input  wire logic [i2cm_pkg::TICKS_W-1:0]       phase_ticks,
  output i2cm_pkg::result_t                       res
);
  import i2cm_pkg::*;

  localparam int PCW  = PHASE_COUNTER_WIDTH;
  localparam int CMPW = ((PCW > TICKS_W) ? PCW : TICKS_W) + 1;

  logic [STEP_W-1:0]   step_r,  step_nxt;
  logic [PCW-1:0]      cnt_r,   cnt_nxt;
  logic [BITCNT_W-1:0] bc_r,    bc_nxt;
  logic [BYTE_W-1:0]   tx_r,    tx_nxt;
  logic [BYTE_W-1:0]   rx_r,    rx_nxt;
  logic                op_r,    op_nxt;
  logic [BYTE_W-1:0]   reg_r,   reg_nxt;
  logic [BYTE_W-1:0]   val_r,   val_nxt;
  lines_t              lines_r, lines_nxt;

  logic [CMPW-1:0] limit;
  logic [CMPW-1:0] cap;
  logic [CMPW-1:0] ticks_ext;

  // phase length: zero counts as one, capped at the counter range
  always_comb begin
    ticks_ext = CMPW'(phase_ticks);
    cap       = CMPW'(1) << PCW;
    limit     = (ticks_ext == '0) ? CMPW'(1) : ticks_ext;
    if (limit > cap) limit = cap;
  end

  always_comb begin
    enter_t          en;
    step_ent_t       ent;
    kind_t           kind;
    logic            busy;
    logic            done;
    logic [CMPW-1:0] cnt_inc;
    logic [BYTE_W-1:0] rd;

    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    bc_nxt    = bc_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    op_nxt    = op_r;
    reg_nxt   = reg_r;
    val_nxt   = val_r;
    lines_nxt = lines_r;
    en        = '0;
    done      = 1'b0;
    rd        = '0;

    // request taken only while idle
    if (step_r == STEP_IDLE && req_valid) begin
      op_nxt    = op;
      reg_nxt   = reg_idx;
      val_nxt   = wr_value;
      rx_nxt    = '0;
      bc_nxt    = '0;
      en        = enter_step(op ? READ_FIRST : WRITE_FIRST, '0, tx_r, dev_addr,
                             reg_idx, wr_value);
      step_nxt  = en.step;
      tx_nxt    = en.tx;
      lines_nxt = en.lines;
      cnt_nxt   = '0;
    end

    ent  = step_entry(step_nxt);
    kind = ent.kind;
    // read bit sampled on the first tick of scl high
    if (kind == K_RXHI && cnt_nxt == '0) rx_nxt = {rx_nxt[BYTE_W-2:0], sda_in};

    busy    = (step_nxt != STEP_IDLE);
    res.scl = lines_nxt.scl;
    res.sda = lines_nxt.sda;
    res.drv = lines_nxt.drv;

    cnt_inc = CMPW'(cnt_nxt) + CMPW'(1);
    if (busy) begin
      if (cnt_inc >= limit) begin
        if (kind == K_TXHI || kind == K_RXHI) begin
          if (bc_nxt < BIT_LAST) begin
            bc_nxt = bc_nxt + BITCNT_W'(1);
            if (kind == K_TXHI) tx_nxt = {tx_nxt[BYTE_W-2:0], 1'b0};
            en = enter_step(step_nxt - STEP_W'(1), bc_nxt, tx_nxt, dev_addr,
                            reg_nxt, val_nxt);
          end else begin
            bc_nxt = '0;
            en = enter_step(step_nxt + STEP_W'(1), bc_nxt, tx_nxt, dev_addr,
                            reg_nxt, val_nxt);
          end
        end else if (kind == K_SPC || kind == K_IDLE) begin
          done   = (kind == K_SPC);
          rd     = op_nxt ? rx_nxt : '0;
          bc_nxt = '0;
          en = enter_step(STEP_IDLE, bc_nxt, tx_nxt, dev_addr, reg_nxt, val_nxt);
        end else begin
          en = enter_step(step_nxt + STEP_W'(1), bc_nxt, tx_nxt, dev_addr,
                          reg_nxt, val_nxt);
        end
        step_nxt  = en.step;
        tx_nxt    = en.tx;
        lines_nxt = en.lines;
        cnt_nxt   = '0;
      end else begin
        cnt_nxt = cnt_inc[PCW-1:0];
      end
    end

    res.busy    = busy;
    res.done    = done;
    res.rd_data = done ? rd : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_IDLE;
      cnt_r   <= '0;
      bc_r    <= '0;
      tx_r    <= '0;
      rx_r    <= '0;
      op_r    <= 1'b0;
      reg_r   <= '0;
      val_r   <= '0;
      lines_r <= LINES_RST;
    end else if (adv) begin
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
      bc_r    <= bc_nxt;
      tx_r    <= tx_nxt;
      rx_r    <= rx_nxt;
      op_r    <= op_nxt;
      reg_r   <= reg_nxt;
      val_r   <= val_nxt;
      lines_r <= lines_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// i2c_master_register_access
// i2c master doing one single-register read or write per request
// ----------------------------------------------------------------------------
//
//   channel  dir  request contents
//   -------  ---  --------------------------------------------------------
//   in_      in   one bus tick: optional request, op, register, value, sda
//   out_     out  one per tick: scl/sda/drive levels, busy, done, read byte
//   cfg_     in   register writes: device address, ticks per half-bit phase
//
// one tick request in, one result request out; the result is presented the
// cycle after the tick is taken, as sequencer state and output register
// update together
// a new tick is taken every cycle while the output register is empty or
// being drained, so in_tready is out_tready or an empty output register
// reset (rst_n low, synchronous) returns the sequencer to idle with scl and
// sda high and driven, device address 50 and 10 ticks per phase
// a stall on the output side holds the sequencer; no tick is dropped
//
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_access #(
  parameter int PHASE_COUNTER_WIDTH = i2cm_pkg::PHASE_CNT_W_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input ticks
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // req_valid, reg_idx[8], wr_value[8], sda_in, pad
  input  wire logic        in_tuser,  // op
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // scl, sda, sda_drive, busy, rd_data[8], pad
  output logic             out_tlast, // done, last tick of a transfer
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import i2cm_pkg::*;

  logic                  in_acc;
  logic [DEV_ADDR_W-1:0] dev_addr_r;
  logic [TICKS_W-1:0]    phase_ticks_r;
  result_t               res;
  logic                  out_valid_r, out_valid_nxt;
  result_t               out_res_r;

  // output register free or draining this cycle
  assign in_tready = out_tready || !out_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  // config registers; a write applies from the next tick on, even mid-transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= DEV_ADDR_RST;
      phase_ticks_r <= PHASE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEV_ADDR:    dev_addr_r    <= cfg_data[DEV_ADDR_W-1:0];
        CFG_PHASE_TICKS: phase_ticks_r <= cfg_data[TICKS_W-1:0];
        default:         ;
      endcase
    end
  end

  // sequencer advances one tick per accepted request
  i2cm_seq #(
    .PHASE_COUNTER_WIDTH(PHASE_COUNTER_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (in_acc),
    .req_valid  (in_tdata[0]),
    .op         (in_tuser),
    .reg_idx    (in_tdata[8:1]),
    .wr_value   (in_tdata[16:9]),
    .sda_in     (in_tdata[17]),
    .dev_addr   (dev_addr_r),
    .phase_ticks(phase_ticks_r),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc)          out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.done;
  assign out_tdata  = {4'b0000, out_res_r.rd_data, out_res_r.busy, out_res_r.drv,
                       out_res_r.sda, out_res_r.scl};

endmodule

`default_nettype wire

FILE: rtl/i2cm_assert_chk.sv
// ----------------------------------------------------------------------------
// i2cm_assert_chk
// port-level checks of the i2c register access block, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_register_access_assert.svh"

module i2cm_assert_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  // stalled result holds
  `I2CM_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // empty output slot never blocks an incoming tick
  `I2CM_ASSERT_RST(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready || !in_tvalid)

  // done only on a busy tick
  `I2CM_ASSERT_RST(a_done_busy, clk, rst_n, out_tvalid && out_tlast |-> out_tdata[3])

  // read byte is zero off the done tick
  `I2CM_ASSERT_RST(a_rd_zero, clk, rst_n, out_tvalid && !out_tlast |-> out_tdata[11:4] == 8'd0)

  // released sda reads as high
  `I2CM_ASSERT_ALL(a_sda_release, clk, rst_n && out_tvalid && !out_tdata[2] |-> out_tdata[1])

endmodule

bind i2c_master_register_access i2cm_assert_chk u_i2cm_assert_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
